// ----- rtl/upe_pkg.sv -----
// shared types and constants for the url percent encoder
`timescale 1ns / 1ps

package upe_pkg;

  localparam int unsigned SCALAR_W     = 21;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUTPUT_LIMIT = 65536;
  localparam int unsigned USED_W       = $clog2(OUTPUT_LIMIT + 1);
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCALAR_W-1:0] SCALAR_MAX     = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] SURROGATE_LOW  = 21'h00D800;
  localparam logic [SCALAR_W-1:0] SURROGATE_HIGH = 21'h00DFFF;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TEXT  = 2'd1,
    ERR_URL   = 2'd2,
    ERR_LARGE = 2'd3
  } err_t;

  // one classified request: either an error or up to four utf-8 bytes
  // raw marks a byte that passes without escaping
  typedef struct packed {
    err_t                   code;
    logic                   first;
    logic                   raw;
    logic [1:0]             last_idx;
    logic [3:0][BYTE_W-1:0] bytes;
  } item_t;

endpackage

// ----- rtl/url_percent_encoder_top.sv -----
// top level of the url percent encoder
`timescale 1ns / 1ps

// Takes one Unicode scalar per request and emits URL text one byte per
// result. In encode mode each scalar becomes UTF-8; unreserved bytes pass
// and every other byte becomes %XY. In raw mode only printable ASCII other
// than space and backslash is accepted. The byte sequencer produces one
// output byte per cycle while the output register is free; a plain byte
// gives one output byte and an escaped byte three. A scalar that yields no
// result (after an error in the same text) needs no output slot. The front
// end accepts a scalar every cycle while the four-entry queue has room; the
// sequencer stalls while a result waits in the output register and is not
// taken. The first result of a request passes through the queue and the
// output register. The first error of a text gives one error result with
// tlast set; later scalars of that text give nothing until a request with
// first set.

module url_percent_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,    // encode_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // [20:0] scalar, upper bits zero
  input  logic        s_tuser,      // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [7:0] out_byte
  output logic [1:0]  m_tuser,      // [1:0] error_code
  output logic        m_tlast       // run_last
);

  upe_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;
  upe_pkg::item_t head_item;
  logic           head_valid;
  logic           head_pop;

  upe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  upe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (front_item),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_item  (head_item),
    .rd_valid (head_valid),
    .rd_pop   (head_pop)
  );

  upe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_item),
    .head_valid (head_valid),
    .pop        (head_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- rtl/upe_front.sv -----
// front end: takes scalars, checks them and converts them to utf-8
`timescale 1ns / 1ps

module upe_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [upe_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output upe_pkg::item_t                  item,
  output logic                            item_valid,
  input  logic                            item_ready
);

  logic                           encode_mode;
  logic [upe_pkg::SCALAR_W-1:0]   sc;
  logic                           bad_text;
  logic                           bad_url;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= 1'b1;
    end else if (cfg_we) begin
      encode_mode <= cfg_wdata;
    end
  end

  assign sc         = s_tdata[upe_pkg::SCALAR_W-1:0];
  assign item_valid = s_tvalid;
  assign s_tready   = item_ready;

  assign bad_text = (sc > upe_pkg::SCALAR_MAX) ||
                    (sc inside {[upe_pkg::SURROGATE_LOW:upe_pkg::SURROGATE_HIGH]});
  // raw mode passes printable ascii except space and backslash
  assign bad_url  = (sc <= 21'd32) || (sc >= 21'd127) || (sc == 21'h00005C);

  always_comb begin
    item          = '0;
    item.first    = s_tuser;
    item.raw      = !encode_mode;
    item.code     = upe_pkg::ERR_NONE;
    item.last_idx = 2'd0;
    item.bytes    = '0;
    if (bad_text) begin
      item.code = upe_pkg::ERR_TEXT;
    end else if (!encode_mode) begin
      if (bad_url) begin
        item.code = upe_pkg::ERR_URL;
      end else begin
        item.bytes[0] = sc[7:0];
      end
    end else if (sc < 21'h000080) begin
      item.bytes[0] = sc[7:0];
    end else if (sc < 21'h000800) begin
      item.last_idx = 2'd1;
      item.bytes[0] = {3'b110, sc[10:6]};
      item.bytes[1] = {2'b10, sc[5:0]};
    end else if (sc < 21'h010000) begin
      item.last_idx = 2'd2;
      item.bytes[0] = {4'b1110, sc[15:12]};
      item.bytes[1] = {2'b10, sc[11:6]};
      item.bytes[2] = {2'b10, sc[5:0]};
    end else begin
      item.last_idx = 2'd3;
      item.bytes[0] = {5'b11110, sc[20:18]};
      item.bytes[1] = {2'b10, sc[17:12]};
      item.bytes[2] = {2'b10, sc[11:6]};
      item.bytes[3] = {2'b10, sc[5:0]};
    end
  end

endmodule

// ----- rtl/upe_queue.sv -----
// short fifo between the front end and the byte sequencer
`timescale 1ns / 1ps

module upe_queue (
  input  logic           clk,
  input  logic           rst,
  input  upe_pkg::item_t wr_item,
  input  logic           wr_valid,
  output logic           wr_ready,
  output upe_pkg::item_t rd_item,
  output logic           rd_valid,
  input  logic           rd_pop
);

  upe_pkg::item_t                entries [upe_pkg::QUEUE_DEPTH];
  logic [upe_pkg::QPTR_W-1:0]    wr_ptr;
  logic [upe_pkg::QPTR_W-1:0]    rd_ptr;
  logic [upe_pkg::QCNT_W-1:0]    count;
  logic                          do_wr;
  logic                          do_rd;

  assign wr_ready = (count != upe_pkg::QCNT_W'(upe_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/upe_back.sv -----
// back end: escapes bytes, tracks output budget and errors, drives the output register
`timescale 1ns / 1ps

module upe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  upe_pkg::item_t              head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [upe_pkg::BYTE_W-1:0]  m_tdata,
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast
);

  typedef enum logic [1:0] {
    POS_LEAD,
    POS_HI,
    POS_LO
  } pos_t;

  localparam logic [upe_pkg::USED_W:0] LIMIT_EXT =
    (upe_pkg::USED_W + 1)'(upe_pkg::OUTPUT_LIMIT);
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                   8'h2D, 8'h2E, 8'h5F, 8'h7E});
    return r;
  endfunction

  logic [upe_pkg::USED_W-1:0]  used, used_next;
  logic                        err_seen, err_next;
  logic                        started, started_next;
  logic [1:0]                  bidx, bidx_next;
  pos_t                        pos, pos_next;

  logic                        eff_clear;
  logic [upe_pkg::USED_W-1:0]  eff_used;
  logic                        eff_err;
  logic [7:0]                  c;
  logic                        unres;
  logic [1:0]                  chunk_len;
  logic [upe_pkg::USED_W:0]    need;
  logic                        fits;
  logic                        out_free;
  logic                        step;
  logic                        emit;
  logic [7:0]                  e_byte;
  upe_pkg::err_t               e_code;
  logic                        e_last;

  // a new text clears the count before its first chunk is checked
  assign eff_clear = head.first && !started;
  assign eff_used  = eff_clear ? '0 : used;
  assign eff_err   = eff_clear ? 1'b0 : err_seen;

  assign c         = head.bytes[bidx];
  // raw text passes as it is
  assign unres     = head.raw || is_unreserved(c);
  assign chunk_len = unres ? 2'd1 : 2'd3;
  assign need      = {1'b0, eff_used} + (upe_pkg::USED_W + 1)'(chunk_len);
  assign fits      = (need <= LIMIT_EXT);
  assign out_free  = !m_tvalid || m_tready;
  // dropped requests need no output slot
  assign step      = head_valid && (out_free || eff_err);

  always_comb begin
    emit         = 1'b0;
    e_byte       = '0;
    e_code       = upe_pkg::ERR_NONE;
    e_last       = 1'b0;
    pop          = 1'b0;
    used_next    = used;
    err_next     = err_seen;
    started_next = started;
    bidx_next    = bidx;
    pos_next     = pos;
    if (step) begin
      used_next    = eff_used;
      err_next     = eff_err;
      started_next = 1'b1;
      if (eff_err) begin
        pop = 1'b1;
      end else if (head.code != upe_pkg::ERR_NONE) begin
        emit     = 1'b1;
        e_code   = head.code;
        e_last   = 1'b1;
        err_next = 1'b1;
        pop      = 1'b1;
      end else begin
        case (pos)
          POS_LEAD: begin
            if (!fits) begin
              emit     = 1'b1;
              e_code   = upe_pkg::ERR_LARGE;
              e_last   = 1'b1;
              err_next = 1'b1;
              pop      = 1'b1;
            end else begin
              emit      = 1'b1;
              e_byte    = unres ? c : CHAR_PERCENT;
              used_next = need[upe_pkg::USED_W-1:0];
              if (!unres) begin
                pos_next = POS_HI;
              end else if (bidx == head.last_idx) begin
                e_last = 1'b1;
                pop    = 1'b1;
              end else begin
                bidx_next = bidx + 2'd1;
              end
            end
          end
          POS_HI: begin
            emit     = 1'b1;
            e_byte   = hex_char(c[7:4]);
            pos_next = POS_LO;
          end
          POS_LO: begin
            emit     = 1'b1;
            e_byte   = hex_char(c[3:0]);
            pos_next = POS_LEAD;
            if (bidx == head.last_idx) begin
              e_last = 1'b1;
              pop    = 1'b1;
            end else begin
              bidx_next = bidx + 2'd1;
            end
          end
          default: begin
            pos_next = POS_LEAD;
          end
        endcase
      end
      if (pop) begin
        started_next = 1'b0;
        bidx_next    = 2'd0;
        pos_next     = POS_LEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      err_seen <= 1'b0;
      started  <= 1'b0;
      bidx     <= 2'd0;
      pos      <= POS_LEAD;
      m_tvalid <= 1'b0;
    end else begin
      used     <= used_next;
      err_seen <= err_next;
      started  <= started_next;
      bidx     <= bidx_next;
      pos      <= pos_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= e_byte;
      m_tuser <= e_code;
      m_tlast <= e_last;
    end
  end

endmodule

// ----- tb/url_percent_encoder_top_tb.sv -----
// self-checking testbench for the url percent encoder top level
`timescale 1ns / 1ps

module url_percent_encoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [upe_pkg::SCALAR_W-1:0] sc;
    logic                         first;
  } scalar_req_t;

  typedef struct packed {
    logic [7:0]    ch;
    upe_pkg::err_t code;
    logic          last;
  } url_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  scalar_req_t pend_q [$];
  url_res_t    exp_q [$];
  scalar_req_t drv_item;
  url_res_t    want;

  // predictor state, mirrors the block's configuration and per-text counters
  logic        mode_r = 1'b1;
  int unsigned used_r = 0;
  bit          err_r = 1'b0;

  bit          steady = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned code_cnt [4] = '{0, 0, 0, 0};

  always #6 clk = ~clk;

  url_percent_encoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
  endfunction

  // expected url text for one accepted scalar
  task automatic predict_scalar(input logic [upe_pkg::SCALAR_W-1:0] sc,
                                input logic first);
    logic [7:0]  utf [4];
    int          n;
    int unsigned len;
    logic [7:0]  c;
    bit          unres;
    url_res_t    outs [$];
    if (first) begin
      used_r = 0;
      err_r = 1'b0;
    end
    if (err_r) return;
    if (sc > upe_pkg::SCALAR_MAX ||
        (sc >= upe_pkg::SURROGATE_LOW && sc <= upe_pkg::SURROGATE_HIGH)) begin
      outs.push_back('{8'h00, upe_pkg::ERR_TEXT, 1'b0});
      err_r = 1'b1;
    end else if (!mode_r && (sc <= 21'd32 || sc >= 21'd127 || sc == 21'h5C)) begin
      outs.push_back('{8'h00, upe_pkg::ERR_URL, 1'b0});
      err_r = 1'b1;
    end else begin
      // raw text is always below 0x80, so it stays a single byte
      if (sc < 21'h80) begin
        n = 1;
        utf[0] = sc[7:0];
      end else if (sc < 21'h800) begin
        n = 2;
        utf[0] = 8'hC0 | {3'd0, sc[10:6]};
        utf[1] = 8'h80 | {2'd0, sc[5:0]};
      end else if (sc < 21'h10000) begin
        n = 3;
        utf[0] = 8'hE0 | {4'd0, sc[15:12]};
        utf[1] = 8'h80 | {2'd0, sc[11:6]};
        utf[2] = 8'h80 | {2'd0, sc[5:0]};
      end else begin
        n = 4;
        utf[0] = 8'hF0 | {5'd0, sc[20:18]};
        utf[1] = 8'h80 | {2'd0, sc[17:12]};
        utf[2] = 8'h80 | {2'd0, sc[11:6]};
        utf[3] = 8'h80 | {2'd0, sc[5:0]};
      end
      for (int i = 0; i < n; i++) begin
        c = utf[i];
        unres = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
        len = (!mode_r || unres) ? 1 : 3;
        // a chunk that does not fit is dropped whole
        if (len > upe_pkg::OUTPUT_LIMIT - used_r) begin
          outs.push_back('{8'h00, upe_pkg::ERR_LARGE, 1'b0});
          err_r = 1'b1;
          break;
        end
        if (len == 1) begin
          outs.push_back('{c, upe_pkg::ERR_NONE, 1'b0});
        end else begin
          outs.push_back('{8'h25, upe_pkg::ERR_NONE, 1'b0});
          outs.push_back('{hex_char(c[7:4]), upe_pkg::ERR_NONE, 1'b0});
          outs.push_back('{hex_char(c[3:0]), upe_pkg::ERR_NONE, 1'b0});
        end
        used_r += len;
      end
    end
    if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[k]) exp_q.push_back(outs[k]);
  endtask

  task automatic add_req(input logic [upe_pkg::SCALAR_W-1:0] sc, input logic first);
    pend_q.push_back('{sc, first});
  endtask

  // mostly well-formed text for the current mode, a little invalid input
  task automatic queue_random(input int count);
    string       unres_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";
    int unsigned k;
    logic [upe_pkg::SCALAR_W-1:0] sc;
    logic        first;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      first = (i == 0) || ($urandom_range(99) < 12);
      if (!mode_r) begin
        if (k < 85) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(126, 33));
          if (sc == 21'h5C && $urandom_range(3) != 0) sc = 21'h5D;
        end else if (k < 91) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(32, 0));
        end else if (k < 95) begin
          sc = ($urandom_range(1) != 0) ? 21'h5C : 21'h7F;
        end else begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'h1FFFFF, 21'h80));
        end
      end else begin
        if (k < 30) begin
          sc = upe_pkg::SCALAR_W'(unres_set[$urandom_range(unres_set.len() - 1)]);
        end else if (k < 50) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'h7F, 0));
        end else if (k < 65) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'h7FF, 21'h80));
        end else if (k < 80) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'hFFFF, 21'h800));
          if (sc >= upe_pkg::SURROGATE_LOW && sc <= upe_pkg::SURROGATE_HIGH)
            sc = sc ^ 21'h2000;
        end else if (k < 96) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'h10FFFF, 21'h10000));
        end else if (k < 98) begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'hDFFF, 21'hD800));
        end else begin
          sc = upe_pkg::SCALAR_W'($urandom_range(21'h1FFFFF, 0));
        end
      end
      add_req(sc, first);
    end
  endtask

  // all requests taken, all results in, then a margin for silent requests
  task automatic settle();
    while (pend_q.size() != 0 || s_tvalid) @(negedge clk);
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    mode_r = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pend_q.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        drv_item = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, drv_item.sc};
        s_tuser <= drv_item.first;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        req_cnt++;
        predict_scalar(s_tdata[upe_pkg::SCALAR_W-1:0], s_tuser);
      end
      if (m_tvalid && m_tready) begin
        res_cnt++;
        code_cnt[m_tuser]++;
        if (exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: byte %02h code %0d last %0b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = exp_q.pop_front();
          if (m_tdata !== want.ch || m_tuser !== want.code || m_tlast !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"mismatch: expected byte %02h code %0d last %0b, ",
                        "got byte %02h code %0d last %0b"},
                       want.ch, want.code, want.last, m_tdata, m_tuser, m_tlast);
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 24);
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (cycle_cnt < CYCLE_LIMIT);
    $display("url_percent_encoder_top test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // encode mode out of reset: unreserved, escaped, every utf-8 length
    add_req(21'h41, 1'b1);
    add_req(21'h7E, 1'b0);
    add_req(21'h2D, 1'b0);
    add_req(21'h2E, 1'b0);
    add_req(21'h5F, 1'b0);
    add_req(21'h30, 1'b0);
    add_req(21'h7A, 1'b0);
    add_req(21'h00, 1'b0);
    add_req(21'h7F, 1'b0);
    add_req(21'h80, 1'b0);
    add_req(21'h7FF, 1'b0);
    add_req(21'h800, 1'b0);
    add_req(21'hFFFF, 1'b0);
    add_req(21'h10000, 1'b0);
    add_req(21'h10FFFF, 1'b0);
    // surrogate ends the text, the next scalar is swallowed
    add_req(21'hD800, 1'b0);
    add_req(21'h42, 1'b0);
    add_req(21'hDFFF, 1'b1);
    add_req(21'hE000, 1'b1);
    add_req(21'h110000, 1'b1);
    add_req(21'h1FFFFF, 1'b1);
    add_req(21'h39, 1'b1);
    settle();

    // raw mode: printable range edges, space, backslash, delete
    set_mode(1'b0);
    add_req(21'h21, 1'b1);
    add_req(21'h7E, 1'b0);
    add_req(21'h20, 1'b1);
    add_req(21'h5C, 1'b1);
    add_req(21'h7F, 1'b1);
    add_req(21'h5B, 1'b1);
    queue_random(100);
    settle();

    // encode mode with both sides running flat out
    set_mode(1'b1);
    steady <= 1'b1;
    queue_random(100);
    settle();
    steady <= 1'b0;

    set_mode(1'b0);
    queue_random(100);
    settle();

    set_mode(1'b1);
    queue_random(100);
    settle();

    $display("covered %0d scalars in both modes, %0d url bytes and error results checked",
             req_cnt, res_cnt);
    $display("errors seen: %0d invalid text, %0d invalid url, %0d output limit",
             code_cnt[upe_pkg::ERR_TEXT], code_cnt[upe_pkg::ERR_URL],
             code_cnt[upe_pkg::ERR_LARGE]);
    if (fail_cnt == 0) begin
      $display("url_percent_encoder_top test passed");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("url_percent_encoder_top test failed");
    end
    $finish;
  end

endmodule

// ----- url_percent_encoder_top.f -----
rtl/upe_pkg.sv
rtl/upe_front.sv
rtl/upe_queue.sv
rtl/upe_back.sv
rtl/url_percent_encoder_top.sv
tb/url_percent_encoder_top_tb.sv
